// ----- rtl/core/ppdr_pkg.sv -----
// ----------------------------------------------------------------------------
// Planar pose dead reckoning: shared package
// Widths, constants, state codes and the arctangent table of the CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

package ppdr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_COUNT   = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
    localparam int IDX_W        = $clog2(ATAN_COUNT);

    // Datapath widths.
    localparam int XY_W  = 34;   // CORDIC x and y, Q30 with headroom
    localparam int Z_W   = 34;   // CORDIC residual angle
    localparam int MA_W  = 35;   // shared multiplier operand A
    localparam int MB_W  = 26;   // shared multiplier operand B
    localparam int MP_W  = MA_W + MB_W;
    localparam int POS_W = 48;
    localparam int RS_W  = 48;   // rotated velocity sum before rounding
    localparam int RV_W  = RS_W - 14;
    localparam int DIV_W = 56;   // dividend bits of the divide by one million
    localparam int REM_W = 20;
    localparam int CNT_MAX = (DIV_W > CORDIC_N + 1) ? DIV_W : CORDIC_N + 1;
    localparam int CNT_W = $clog2(CNT_MAX);

    // Divide by one million through a reciprocal: the first estimate uses the
    // dividend without its low DIV_PRE bits, the second the remainder.
    localparam int DIV_PRE  = 19;
    localparam int RECIP_SH = 44;
    localparam int Q2_W     = 16;   // second quotient estimate

    localparam logic [24:0]        HEAD_GAIN   = 25'd22399067;
    localparam logic [24:0]        RECIP_MIL   = 25'd17592186;  // floor(2^44 / 10^6)
    localparam logic [XY_W-1:0]    CORDIC_X0   = XY_W'(652032874);
    localparam logic [REM_W-1:0]   MILLION     = REM_W'(1000000);
    localparam logic [MP_W-1:0]    HALF_MIL    = MP_W'(500000);
    localparam logic [MP_W-1:0]    HALF_MIL_P1 = MP_W'(500001);
    localparam logic signed [11:0] START_X_RST = -12'sd650;
    localparam logic signed [11:0] START_Y_RST = -12'sd350;

    // Input operation codes.
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_START_X = 1'b0;
    localparam logic CFG_START_Y = 1'b1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HEAD  = 8'b0000_0010,
        S_CINIT = 8'b0000_0100,
        S_CORD  = 8'b0000_1000,
        S_VEL   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_POSE  = 8'b0100_0000,
        S_QUAT  = 8'b1000_0000
    } t_state;

    // Arctangent of 2^-i, 2^32 equals two pi.
    function automatic logic signed [Z_W-1:0] atan_val(input logic [IDX_W-1:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return $signed({{(Z_W-32){1'b0}}, v});
    endfunction

    // Q30 to Q15, rounded half away from zero, saturated.
    function automatic logic [15:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [XY_W-16:0] r;
        s = v + $signed(XY_W'(16384)) - $signed({{(XY_W-1){1'b0}}, v[XY_W-1]});
        r = s[XY_W-1:15];
        if (r > $signed((XY_W-15)'(32767))) begin
            return 16'h7FFF;
        end else if (r < -$signed((XY_W-15)'(32768))) begin
            return 16'h8000;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/planar_pose_dead_reckoning.sv -----
// ----------------------------------------------------------------------------
// Planar pose dead reckoning integrator
// Integrates body velocities and yaw rate into a planar pose and reports the
// pose with the half-angle quaternion, using one shared multiplier and one
// CORDIC stage under a small sequencer; the divide by one million is done by
// reciprocal multiplication on the shared multiplier.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                     Content
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tick or restart item
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  pose result
//  cfg       in         i_cfg_valid/o_cfg_ready         start point registers
//
//  A tick transaction runs the heading product, a CORDIC pass for the
//  rotation, the rotated velocity products, the divide by one million,
//  the pose update, a second CORDIC pass for the half-angle quaternion and
//  the load of the result, which waits while an earlier result is stalled.
//  The next item is accepted only in the idle state after that load.
//  A restart transaction runs the quaternion CORDIC pass and the load.
//  Reset (synchronous, active low) loads the start point registers with
//  their defaults and the pose with that start point at heading zero.
//  A stalled result sits in the output register while the next input
//  transaction is already accepted and processed.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_dead_reckoning (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // tdata: vel_x[15:0], vel_y[31:16], yaw_rate[47:32], elapsed_us[67:48], zero pad
    input  wire logic [71:0]  i_s_axis_tdata,
    // tuser: op (0 tick, 1 restart)
    input  wire logic         i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // tdata: pos_x[47:0], pos_y[95:48], heading[127:96], quat_z[143:128],
    //        quat_w[159:144]
    output logic [159:0]      o_m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [11:0]  i_cfg_data
);
    import ppdr_pkg::*;

    t_state r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_pass;      // 0: full-angle rotation, 1: half-angle quaternion

    // Configuration and pose state.
    logic signed [11:0]      r_start_x, r_start_y;
    logic [POS_W-1:0]        r_pose_x, r_pose_y;
    logic [31:0]             r_heading;

    // Captured input transaction.
    logic signed [15:0]      r_vx, r_vy;
    logic [15:0]             r_mag;
    logic                    r_yneg;
    logic [19:0]             r_us;

    // Shared multiplier.
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [MP_W-1:0]  r_prod;
    logic signed [MP_W-1:0]  r_acc;
    logic signed [RS_W-1:0]  r_rsum;
    logic signed [RV_W-1:0]  r_rx, r_ry;
    logic [31:0]             r_step;

    // CORDIC.
    logic signed [XY_W-1:0]  r_cx, r_cy;
    logic signed [Z_W-1:0]   r_cz;
    logic                    r_flip;

    // Divider lanes: dividend and remainder, quotient, second estimate.
    logic [DIV_W-1:0]        r_dqx, r_dqy;
    logic [POS_W-1:0]        r_qtx, r_qty;
    logic [Q2_W-1:0]         r_q2x, r_q2y;
    logic                    r_sx, r_sy;

    // Output register.
    logic                    r_out_valid;
    logic [159:0]            r_out_data;

    logic [IDX_W-1:0]        idx;
    logic signed [XY_W-1:0]  sh_x, sh_y;
    logic signed [Z_W-1:0]   atan_i;
    logic [31:0]             c_ang, c_turn, c_ang2;
    logic [63:0]             head_sum;
    logic signed [RS_W-1:0]  rnd_sum;
    logic signed [RV_W-1:0]  n_rv;
    logic                    prod_neg;
    logic [MP_W-1:0]         n_dividend;
    logic                    gex, gey;
    logic                    out_free;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // Operand selection of the shared multiplier by step.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_HEAD: begin
                case (r_cnt)
                    CNT_W'(0): begin
                        mul_a = $signed({{(MA_W-16){1'b0}}, r_mag});
                        mul_b = $signed({{(MB_W-20){1'b0}}, r_us});
                    end
                    CNT_W'(1): begin
                        mul_a = $signed({{(MA_W-18){1'b0}}, r_prod[17:0]});
                        mul_b = $signed({1'b0, HEAD_GAIN});
                    end
                    CNT_W'(2): begin
                        mul_a = $signed({{(MA_W-18){1'b0}}, r_acc[35:18]});
                        mul_b = $signed({1'b0, HEAD_GAIN});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_VEL: begin
                case (r_cnt)
                    CNT_W'(0): begin
                        mul_a = MA_W'(r_cx);
                        mul_b = MB_W'(r_vx);
                    end
                    CNT_W'(1): begin
                        mul_a = MA_W'(r_cy);
                        mul_b = MB_W'(r_vy);
                    end
                    CNT_W'(2): begin
                        mul_a = MA_W'(r_cy);
                        mul_b = MB_W'(r_vx);
                    end
                    CNT_W'(3): begin
                        mul_a = MA_W'(r_cx);
                        mul_b = MB_W'(r_vy);
                    end
                    CNT_W'(4): begin
                        mul_a = MA_W'(r_rx);
                        mul_b = $signed({{(MB_W-20){1'b0}}, r_us});
                    end
                    CNT_W'(6): begin
                        mul_a = MA_W'(r_ry);
                        mul_b = $signed({{(MB_W-20){1'b0}}, r_us});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            S_DIV: begin
                case (r_cnt)
                    CNT_W'(0): begin
                        mul_a = $signed({1'b0, r_dqx[DIV_PRE+MA_W-2:DIV_PRE]});
                        mul_b = $signed({1'b0, RECIP_MIL});
                    end
                    CNT_W'(1): begin
                        mul_a = $signed({1'b0, r_dqy[DIV_PRE+MA_W-2:DIV_PRE]});
                        mul_b = $signed({1'b0, RECIP_MIL});
                    end
                    CNT_W'(2): begin
                        mul_a = $signed({1'b0, r_qtx[MA_W-2:0]});
                        mul_b = $signed({{(MB_W-REM_W){1'b0}}, MILLION});
                    end
                    CNT_W'(3): begin
                        mul_a = $signed({1'b0, r_qty[MA_W-2:0]});
                        mul_b = $signed({{(MB_W-REM_W){1'b0}}, MILLION});
                    end
                    CNT_W'(4): begin
                        mul_a = $signed({1'b0, r_dqx[MA_W-2:0]});
                        mul_b = $signed({1'b0, RECIP_MIL});
                    end
                    CNT_W'(5): begin
                        mul_a = $signed({1'b0, r_dqy[MA_W-2:0]});
                        mul_b = $signed({1'b0, RECIP_MIL});
                    end
                    CNT_W'(6): begin
                        mul_a = $signed({{(MA_W-Q2_W){1'b0}}, r_q2x});
                        mul_b = $signed({{(MB_W-REM_W){1'b0}}, MILLION});
                    end
                    CNT_W'(7): begin
                        mul_a = $signed({{(MA_W-Q2_W){1'b0}}, r_q2y});
                        mul_b = $signed({{(MB_W-REM_W){1'b0}}, MILLION});
                    end
                    default: begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        idx    = r_cnt[IDX_W-1:0];
        sh_x   = r_cx >>> idx;
        sh_y   = r_cy >>> idx;
        atan_i = atan_val(idx);

        // The quaternion pass works on the heading itself, the rotation pass
        // on twice the heading. Angles in the left half-plane are turned by pi.
        c_ang  = r_pass ? r_heading : {r_heading[30:0], 1'b0};
        c_turn = c_ang + 32'h4000_0000;
        c_ang2 = {c_ang[31] ^ c_turn[31], c_ang[30:0]};

        // Heading step: low and high partial products of p times the gain.
        head_sum = 64'(r_acc) + {r_prod[63-18:0], 18'b0} + 64'h0800_0000;

        // Round half away from zero by 2^14 as one add.
        rnd_sum = r_rsum + $signed(RS_W'(8192))
                  - $signed({{(RS_W-1){1'b0}}, r_rsum[RS_W-1]});
        n_rv    = rnd_sum[RS_W-1:14];

        // Magnitude of the time product plus half of one million.
        prod_neg   = r_prod[MP_W-1];
        n_dividend = prod_neg ? (~r_prod + HALF_MIL_P1) : (r_prod + HALF_MIL);

        // The remainder left after both estimates is below two million.
        gex = (r_dqx >= DIV_W'(MILLION));
        gey = (r_dqy >= DIV_W'(MILLION));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MP_W'(mul_a * mul_b);

        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
            r_start_x   <= START_X_RST;
            r_start_y   <= START_Y_RST;
            r_pose_x    <= {{(POS_W-28){START_X_RST[11]}}, START_X_RST, 16'b0};
            r_pose_y    <= {{(POS_W-28){START_Y_RST[11]}}, START_Y_RST, 16'b0};
            r_heading   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_START_X: r_start_x <= i_cfg_data;
                    CFG_START_Y: r_start_y <= i_cfg_data;
                    default: ;
                endcase
            end

            // In S_QUAT the output register is reloaded below instead.
            if (r_out_valid && i_m_axis_tready && (r_state != S_QUAT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_s_axis_tvalid) begin
                        r_vx   <= i_s_axis_tdata[15:0];
                        r_vy   <= i_s_axis_tdata[31:16];
                        r_yneg <= i_s_axis_tdata[47];
                        r_mag  <= i_s_axis_tdata[47] ? (16'd0 - i_s_axis_tdata[47:32])
                                                     : i_s_axis_tdata[47:32];
                        r_us   <= i_s_axis_tdata[67:48];
                        if (i_s_axis_tuser == OP_RESTART) begin
                            r_pose_x  <= {{(POS_W-28){r_start_x[11]}}, r_start_x, 16'b0};
                            r_pose_y  <= {{(POS_W-28){r_start_y[11]}}, r_start_y, 16'b0};
                            r_heading <= '0;
                            r_pass    <= 1'b1;
                            r_state   <= S_CINIT;
                        end else begin
                            r_pass  <= 1'b0;
                            r_state <= S_HEAD;
                        end
                    end
                end
                S_HEAD: begin
                    r_cnt <= r_cnt + 1'b1;
                    case (r_cnt)
                        CNT_W'(1), CNT_W'(2): r_acc <= r_prod;
                        CNT_W'(3): r_step <= head_sum[59:28];
                        CNT_W'(4): begin
                            r_heading <= r_yneg ? (r_heading - r_step) : (r_heading + r_step);
                            r_state   <= S_CINIT;
                        end
                        default: ;
                    endcase
                end
                S_CINIT: begin
                    r_cx    <= CORDIC_X0;
                    r_cy    <= '0;
                    r_cz    <= $signed({{(Z_W-32){c_ang2[31]}}, c_ang2});
                    r_flip  <= c_turn[31];
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (r_cnt == CNT_W'(CORDIC_N)) begin
                        if (r_flip) begin
                            r_cx <= -r_cx;
                            r_cy <= -r_cy;
                        end
                        r_cnt   <= '0;
                        r_state <= r_pass ? S_QUAT : S_VEL;
                    end else begin
                        if (!r_cz[Z_W-1]) begin
                            r_cx <= r_cx - sh_y;
                            r_cy <= r_cy + sh_x;
                            r_cz <= r_cz - atan_i;
                        end else begin
                            r_cx <= r_cx + sh_y;
                            r_cy <= r_cy - sh_x;
                            r_cz <= r_cz + atan_i;
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_VEL: begin
                    r_cnt <= (r_cnt == CNT_W'(7)) ? '0 : r_cnt + 1'b1;
                    case (r_cnt)
                        CNT_W'(1): r_acc <= r_prod;
                        CNT_W'(2): r_rsum <= r_acc[RS_W-1:0] - r_prod[RS_W-1:0];
                        CNT_W'(3): begin
                            r_rx  <= n_rv;
                            r_acc <= r_prod;
                        end
                        CNT_W'(4): r_rsum <= r_acc[RS_W-1:0] + r_prod[RS_W-1:0];
                        CNT_W'(5): begin
                            r_ry   <= n_rv;
                            r_dqx  <= n_dividend[DIV_W-1:0];
                            r_sx   <= prod_neg;
                        end
                        CNT_W'(7): begin
                            r_dqy   <= n_dividend[DIV_W-1:0];
                            r_sy    <= prod_neg;
                            r_state <= S_DIV;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    // A first quotient estimate from the upper dividend bits
                    // falls short by a few hundred at most; a second estimate
                    // from the remainder leaves less than two million, which
                    // the pose step corrects with one compare. The x and y
                    // lanes take turns on the multiplier.
                    case (r_cnt)
                        CNT_W'(1): r_qtx <= POS_W'(r_prod[MP_W-1:RECIP_SH-DIV_PRE]);
                        CNT_W'(2): r_qty <= POS_W'(r_prod[MP_W-1:RECIP_SH-DIV_PRE]);
                        CNT_W'(3): r_dqx <= r_dqx - r_prod[DIV_W-1:0];
                        CNT_W'(4): r_dqy <= r_dqy - r_prod[DIV_W-1:0];
                        CNT_W'(5): begin
                            r_q2x <= r_prod[RECIP_SH+Q2_W-1:RECIP_SH];
                            r_qtx <= r_qtx + POS_W'(r_prod[RECIP_SH+Q2_W-1:RECIP_SH]);
                        end
                        CNT_W'(6): begin
                            r_q2y <= r_prod[RECIP_SH+Q2_W-1:RECIP_SH];
                            r_qty <= r_qty + POS_W'(r_prod[RECIP_SH+Q2_W-1:RECIP_SH]);
                        end
                        CNT_W'(7): r_dqx <= r_dqx - r_prod[DIV_W-1:0];
                        CNT_W'(8): r_dqy <= r_dqy - r_prod[DIV_W-1:0];
                        default: ;
                    endcase
                    if (r_cnt == CNT_W'(8)) begin
                        r_cnt   <= '0;
                        r_state <= S_POSE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_POSE: begin
                    r_pose_x <= r_sx ? (r_pose_x - (r_qtx + POS_W'(gex)))
                                     : (r_pose_x + (r_qtx + POS_W'(gex)));
                    r_pose_y <= r_sy ? (r_pose_y - (r_qty + POS_W'(gey)))
                                     : (r_pose_y + (r_qty + POS_W'(gey)));
                    r_pass   <= 1'b1;
                    r_state  <= S_CINIT;
                end
                S_QUAT: begin
                    if (out_free) begin
                        r_out_data  <= {to_q15(r_cx), to_q15(r_cy), r_heading,
                                        r_pose_y, r_pose_x};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ppdr_checker.sv -----
// ----------------------------------------------------------------------------
// Planar pose dead reckoning: port checker
// Watches the top-level ports of the integrator over time.
// ----------------------------------------------------------------------------
`default_nettype none

module ppdr_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [159:0] o_m_axis_tdata
);

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // An accepted input transaction keeps the block busy in the next cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready right after a transaction");

    // A result only appears at the end of work on an item.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result without work in progress");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind planar_pose_dead_reckoning ppdr_checker u_ppdr_checker (.*);

`default_nettype wire

// ----- tb/ppdr_pose_checker.sv -----
// ----------------------------------------------------------------------------
// Planar pose dead reckoning: pose checker
// Watches the configuration, input and result channels, keeps its own copy
// of the start point, pose and heading, predicts each pose result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module ppdr_pose_checker
    import ppdr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    input  wire logic         i_s_axis_tready,
    input  wire logic [71:0]  i_s_axis_tdata,
    input  wire logic         i_s_axis_tuser,
    input  wire logic         i_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    input  wire logic [159:0] i_m_axis_tdata,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic         i_cfg_index,
    input  wire logic [11:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [31:0] heading;
        logic [15:0] quat_z;
        logic [15:0] quat_w;
    } pose_t;

    localparam longint ARCTAN [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
    };

    pose_t       expected_poses[$];
    logic [11:0] start_x;
    logic [11:0] start_y;
    logic [47:0] pose_x;
    logic [47:0] pose_y;
    logic [31:0] heading;

    initial o_errors = 0;
    assign o_pending = expected_poses.size();

    // Rounds v / 2^s half away from zero.
    function automatic longint round_shift(longint v, int s);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? -v : v;
        q = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint round_div_million(longint v);
        longint unsigned mag;
        longint unsigned q;
        mag = (v < 0) ? -v : v;
        q = (mag + 64'd500000) / 64'd1000000;
        return (v < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Rotation-mode CORDIC on a binary angle where 2^32 is two pi, Q30 out.
    task automatic sin_cos(input logic [31:0] angle, output longint c, output longint s);
        logic [31:0] a;
        logic [31:0] probe;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      t;
        a = angle;
        probe = a + 32'h4000_0000;
        flip = probe[31];
        if (flip) begin
            a = a - 32'h8000_0000;
        end
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - ARCTAN[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + ARCTAN[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic logic [15:0] q30_to_q15(longint v);
        longint r;
        r = round_shift(v, 15);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic restart_pose();
        pose_x = {{20{start_x[11]}}, start_x, 16'd0};
        pose_y = {{20{start_y[11]}}, start_y, 16'd0};
        heading = '0;
    endtask

    // Advances the pose by one item and queues the pose it should report.
    task automatic advance_pose(input logic op, input logic [71:0] data);
        longint          vx;
        longint          vy;
        longint          yr;
        longint          us;
        longint unsigned prod;
        logic [31:0]     step;
        longint          c;
        longint          s;
        longint          rx;
        longint          ry;
        pose_t           p;
        if (op == OP_RESTART) begin
            restart_pose();
        end else begin
            vx = longint'($signed(data[15:0]));
            vy = longint'($signed(data[31:16]));
            yr = longint'($signed(data[47:32]));
            us = longint'(data[67:48]);
            prod = ((yr < 0) ? -yr : yr) * us * 64'd22399067 + (64'd1 << 27);
            step = 32'(prod >> 28);
            heading = (yr < 0) ? heading - step : heading + step;
            sin_cos({heading[30:0], 1'b0}, c, s);
            rx = round_shift(c * vx - s * vy, 14);
            ry = round_shift(s * vx + c * vy, 14);
            pose_x = pose_x + 48'(round_div_million(rx * us));
            pose_y = pose_y + 48'(round_div_million(ry * us));
        end
        sin_cos(heading, c, s);
        p.pos_x = pose_x;
        p.pos_y = pose_y;
        p.heading = heading;
        p.quat_z = q30_to_q15(s);
        p.quat_w = q30_to_q15(c);
        expected_poses.push_back(p);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] pose mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        pose_t p;
        if (!i_rst_n) begin
            start_x <= START_X_RST;
            start_y <= START_Y_RST;
            pose_x = {{20{START_X_RST[11]}}, START_X_RST, 16'd0};
            pose_y = {{20{START_Y_RST[11]}}, START_Y_RST, 16'd0};
            heading = '0;
        end else begin
            // A register write only matters at the next restart, and writes
            // never share a cycle with input transactions here.
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_START_X) start_x <= i_cfg_data;
                else start_y <= i_cfg_data;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                advance_pose(i_s_axis_tuser, i_s_axis_tdata);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_poses.size() == 0) begin
                    report_mismatch("unexpected result", i_m_axis_tdata[63:0], '0);
                end else begin
                    p = expected_poses.pop_front();
                    if (i_m_axis_tdata[47:0] !== p.pos_x)
                        report_mismatch("pos_x", i_m_axis_tdata[47:0], p.pos_x);
                    if (i_m_axis_tdata[95:48] !== p.pos_y)
                        report_mismatch("pos_y", i_m_axis_tdata[95:48], p.pos_y);
                    if (i_m_axis_tdata[127:96] !== p.heading)
                        report_mismatch("heading", i_m_axis_tdata[127:96], p.heading);
                    if (i_m_axis_tdata[143:128] !== p.quat_z)
                        report_mismatch("quat_z", i_m_axis_tdata[143:128], p.quat_z);
                    if (i_m_axis_tdata[159:144] !== p.quat_w)
                        report_mismatch("quat_w", i_m_axis_tdata[159:144], p.quat_w);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/planar_pose_dead_reckoning_tb.sv -----
// ----------------------------------------------------------------------------
// Planar pose dead reckoning: testbench top
// Drives tick and restart transactions and start point writes through several
// configuration phases, with random gaps and receiver stalls; the pose
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_pose_dead_reckoning_tb;
    import ppdr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 150;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    // tdata: vel_x[15:0], vel_y[31:16], yaw_rate[47:32], elapsed_us[67:48], zero pad
    logic [71:0]  i_s_axis_tdata = '0;
    // tuser: op
    logic         i_s_axis_tuser = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    // tdata: pos_x[47:0], pos_y[95:48], heading[127:96], quat_z[143:128], quat_w[159:144]
    logic [159:0] o_m_axis_tdata;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_index = CFG_START_X;
    logic [11:0]  i_cfg_data = '0;

    int errors;
    int pending;
    int sent_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    planar_pose_dead_reckoning i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    ppdr_pose_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_errors        (errors),
        .o_pending       (pending)
    );

    // Offers one input transaction and holds it until the block takes it.
    // Valid stays high afterwards so back-to-back items need no extra edge.
    task automatic send_item(input logic op, input logic [15:0] vx, input logic [15:0] vy,
                             input logic [15:0] yr, input logic [19:0] us);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= op;
        i_s_axis_tdata <= {4'd0, us, yr, vy, vx};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sent_count++;
    endtask

    // Random sender gap: mostly none, some short, a few long. Every fourth
    // block of a hundred items runs without gaps at all.
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80);
        if ((sent_count / 100) % 4 == 3) n = 0;
        if (n > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [11:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Lowers valid and lets every queued pose come back before the
    // configuration changes.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [19:0] us;
        us = ($urandom_range(0, 4) == 0) ? 20'($urandom_range(0, 20'hFFFFF))
                                         : 20'($urandom_range(0, 999999));
        send_item(($urandom_range(0, 19) == 0) ? OP_RESTART : OP_TICK,
                  16'($urandom), 16'($urandom), 16'($urandom), us);
        sender_gap();
    endtask

    // Receiver: calm stretches with ready held high, random stretches with
    // short and occasional long stalls, and one long hold-off that lets the
    // block fill up and push back on the sender.
    initial begin
        int cyc;
        cyc = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc == 6000) begin
                i_m_axis_tready <= 1'b0;
                repeat (900) @(posedge i_clk);
            end else if ((cyc / 500) % 3 == 0) begin
                i_m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        logic [11:0] xs[6];
        logic [11:0] ys[6];
        xs = '{12'h000, 12'h800, 12'h7FF, 12'h000, 12'h830, 12'h000};
        ys = '{12'h000, 12'h7FF, 12'h800, 12'h000, 12'h7D0, 12'h000};
        xs[5] = 12'($urandom);
        ys[5] = 12'($urandom);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under the reset start point: zero motion, full
        // scale velocities and yaw rates of both signs, zero time, time above
        // one second, heading wrap below zero, and a restart mid-run.
        send_item(OP_TICK, 16'h0000, 16'h0000, 16'h0000, 20'd0);
        send_item(OP_TICK, 16'h7FFF, 16'h8000, 16'h7FFF, 20'd999999);
        send_item(OP_TICK, 16'h8000, 16'h7FFF, 16'h8000, 20'hFFFFF);
        send_item(OP_TICK, 16'h7FFF, 16'h7FFF, 16'h7FFF, 20'd0);
        send_item(OP_TICK, 16'h8000, 16'h8000, 16'h0001, 20'd1);
        send_item(OP_RESTART, 16'h1234, 16'h5678, 16'h7FFF, 20'd999999);
        send_item(OP_TICK, 16'h0000, 16'h0000, 16'hFFFF, 20'd1);
        send_item(OP_TICK, 16'h03E8, 16'h0000, 16'h8000, 20'd500000);
        send_item(OP_TICK, 16'hFC18, 16'h01F4, 16'h4000, 20'd999999);
        send_item(OP_TICK, 16'h0001, 16'hFFFF, 16'h7FFF, 20'd999999);
        send_item(OP_TICK, 16'h7FFF, 16'h0000, 16'h7FFF, 20'hFFFFF);
        send_item(OP_RESTART, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
        sender_gap();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase > 0) begin
                drain();
                write_reg(CFG_START_X, xs[phase]);
                write_reg(CFG_START_Y, ys[phase]);
                // A tick first shows the write has not taken effect yet.
                send_item(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom),
                          20'($urandom_range(0, 999999)));
                send_item(OP_RESTART, '0, '0, '0, '0);
            end
            repeat (ITEMS_PER_PHASE) random_item();
        end

        drain();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/ppdr_pkg.sv
rtl/core/planar_pose_dead_reckoning.sv
rtl/core/ppdr_checker.sv
tb/ppdr_pose_checker.sv
tb/planar_pose_dead_reckoning_tb.sv
